### sv/table_interpolator_macros.svh
// assertion macros for the table interpolator
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef TABLE_INTERPOLATOR_MACROS_SVH
`define TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TI_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ti_pkg.sv
// shared types and constants of the table interpolator
// no dependencies
`default_nettype none

package ti_pkg;

    // field and arithmetic widths
    localparam int XW     = 32;  // table abscissa / ordinate
    localparam int DW     = 33;  // exact difference of two table values
    localparam int PW     = 66;  // product of two differences
    localparam int NUMW   = 99;  // three-factor numerator
    localparam int REMW   = 65;  // divider remainder
    localparam int QW     = 41;  // quotient bits kept before clamping
    localparam int QCW    = $clog2(QW);
    localparam int SW     = 44;  // running sum of terms
    localparam int CFG_DW = 7;
    localparam int CFG_IW = 1;

    localparam logic [QW-1:0] TERM_CLAMP = {1'b1, {(QW-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_METHOD = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_COUNT  = 1'b1;

    // interpolation modes
    localparam logic [1:0] METHOD_NEAREST = 2'd0;
    localparam logic [1:0] METHOD_LINEAR  = 2'd1;
    localparam logic [1:0] METHOD_QUAD    = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_INSIDE = 2'd0;
    localparam logic [1:0] STAT_BELOW  = 2'd1;
    localparam logic [1:0] STAT_ABOVE  = 2'd2;

    typedef enum logic [1:0] {TERM_LIN, TERM_A, TERM_B, TERM_C} t_term;

    typedef enum logic [1:0] {RES_B, RES_NEAR, RES_SUM} t_res_sel;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_SHIFT, OP_PICK, OP_SUM_LIN, OP_SUM_ZERO,
        OP_OPERANDS, OP_MUL_N, OP_MUL_D, OP_MUL_LO, OP_MUL_HI, OP_NUM_ADD,
        OP_DIV_INIT, OP_DIV_STEP, OP_ACC, OP_RESULT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD0, S_FIRST, S_SCAN, S_NEAR, S_ABOVE, S_PICK, S_LINSET,
        S_QSET, S_OPS, S_MULN, S_MULD, S_MULLO, S_MULHI, S_NUMADD, S_DIVINIT,
        S_DIV, S_ACC, S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        t_op        op;
        t_term      term;
        t_res_sel   res_sel;
        logic [1:0] status;
        logic       has_lo;
        logic       has_hi;
        logic       wr_en;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic le_first;
        logic lt_first;
        logic found;
        logic far_eq;
    } t_st;

endpackage

`default_nettype wire

### sv/ti_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module ti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/ti_dp.sv
// datapath: point table, segment registers, multiplier, divider, result
// depends on ti_pkg and ti_ram
`default_nettype none

module ti_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ti_pkg::t_cmd                   i_cmd,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    input  wire logic [5:0]                     i_index,
    input  wire logic [ti_pkg::XW-1:0]          i_abscissa,
    input  wire logic [ti_pkg::XW-1:0]          i_ordinate,
    output      ti_pkg::t_st                    o_st,
    output      logic                           o_valid,
    output      logic [ti_pkg::XW-1:0]          o_value,
    output      logic [1:0]                     o_status
);

    import ti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = ((AW > 6) ? AW : 6) + 1;
    localparam logic signed [63:0] VMAX =
        {{(64-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [63:0] VMIN = ~VMAX;

    function automatic logic [DW-1:0] sdiff(input logic [XW-1:0] a, input logic [XW-1:0] b);
        return {a[XW-1], a} - {b[XW-1], b};
    endfunction

    function automatic logic slt(input logic [XW-1:0] a, input logic [XW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    // table storage, abscissa in the upper half
    logic [IW-1:0]   w_idx;
    logic            w_we;
    logic [2*XW-1:0] w_rd;
    logic [XW-1:0]   w_rd_x;
    logic [XW-1:0]   w_rd_y;

    assign w_idx = IW'(i_index);
    assign w_we  = i_cmd.wr_en && (w_idx < IW'(TABLE_DEPTH));

    ti_ram #(
        .WIDTH(2*XW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_idx[AW-1:0]),
        .i_wdata({i_abscissa, i_ordinate}),
        .i_raddr(i_raddr),
        .o_rdata(w_rd)
    );

    assign w_rd_x = w_rd[2*XW-1:XW];
    assign w_rd_y = w_rd[XW-1:0];

    // query and segment points: m2 = i-2, a = i-1, b = i, c = third point
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_xm2, r_ym2, r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;

    // term operands and arithmetic state
    logic [DW-1:0]   r_my, r_mn1, r_mn2, r_md1, r_md2;
    logic            r_neg;
    logic [PW-1:0]   r_p, r_nn, r_den;
    logic [NUMW-1:0] r_num;
    logic [REMW-1:0] r_rem;
    logic [QW-1:0]   r_qsh, r_q;
    logic            r_clamp;
    logic [SW-1:0]   r_sum;
    logic            r_valid;
    logic [XW-1:0]   r_value;
    logic [1:0]      r_status;

    // segment tests
    logic          w_lo_nearer, w_use_lo, w_near;
    logic [XW-1:0] w_far_x, w_far_y;

    assign w_lo_nearer = $signed(sdiff(r_x, r_xm2)) < $signed(sdiff(w_rd_x, r_x));
    assign w_use_lo    = i_cmd.has_lo && (!i_cmd.has_hi || w_lo_nearer);
    assign w_far_x     = w_use_lo ? r_xm2 : w_rd_x;
    assign w_far_y     = w_use_lo ? r_ym2 : w_rd_y;
    assign w_near      = $signed(sdiff(r_x, r_xa)) < $signed(sdiff(r_xb, r_x));

    assign o_st.le_first = !slt(r_xb, r_x);
    assign o_st.lt_first = slt(r_x, r_xb);
    assign o_st.found    = !slt(r_x, r_xb) && slt(r_x, w_rd_x);
    assign o_st.far_eq   = (w_far_x == r_xa) || (w_far_x == r_xb);

    // operand selection for the current term
    logic [XW-1:0] w_own_x, w_own_y, w_o1_x, w_o2_x;
    logic [DW-1:0] w_y, w_n1, w_n2, w_d1, w_d2;

    always_comb begin
        unique case (i_cmd.term)
            TERM_A: begin
                w_own_x = r_xa; w_own_y = r_ya; w_o1_x = r_xb; w_o2_x = r_xc;
            end
            TERM_B: begin
                w_own_x = r_xb; w_own_y = r_yb; w_o1_x = r_xa; w_o2_x = r_xc;
            end
            TERM_C: begin
                w_own_x = r_xc; w_own_y = r_yc; w_o1_x = r_xa; w_o2_x = r_xb;
            end
            default: begin
                w_own_x = r_xb; w_own_y = r_yb; w_o1_x = r_xa; w_o2_x = r_xc;
            end
        endcase
        w_n1 = sdiff(r_x, w_o1_x);
        w_d1 = sdiff(w_own_x, w_o1_x);
        if (i_cmd.term == TERM_LIN) begin
            w_y  = sdiff(r_yb, r_ya);
            w_n2 = DW'(1);
            w_d2 = DW'(1);
        end else begin
            w_y  = {w_own_y[XW-1], w_own_y};
            w_n2 = sdiff(r_x, w_o2_x);
            w_d2 = sdiff(w_own_x, w_o2_x);
        end
    end

    // shared 33 x 33 multiplier
    logic [DW-1:0] w_ma, w_mb;
    logic [PW-1:0] w_prod;

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_D:  begin w_ma = r_md1;          w_mb = r_md2; end
            OP_MUL_LO: begin w_ma = r_nn[DW-1:0];   w_mb = r_my;  end
            OP_MUL_HI: begin w_ma = r_nn[PW-1:DW];  w_mb = r_my;  end
            default:   begin w_ma = r_mn1;          w_mb = r_mn2; end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // restoring division, one quotient bit a step
    logic [PW-1:0] w_num_hi, w_trial;
    logic          w_ge;

    assign w_num_hi = PW'(r_num[NUMW-1:QW]);
    assign w_trial  = {r_rem, r_qsh[QW-1]};
    assign w_ge     = w_trial >= r_den;

    // clamped signed term
    logic [QW-1:0] w_m;
    logic [SW-1:0] w_term;

    assign w_m    = (r_clamp || (r_q > TERM_CLAMP)) ? TERM_CLAMP : r_q;
    assign w_term = r_neg ? (SW'(0) - SW'(w_m)) : SW'(w_m);

    // result selection and saturation
    logic signed [63:0] w_res, w_sat;

    always_comb begin
        unique case (i_cmd.res_sel)
            RES_NEAR: w_res = 64'($signed(w_near ? r_ya : r_yb));
            RES_SUM:  w_res = 64'($signed(r_sum));
            default:  w_res = 64'($signed(r_yb));
        endcase
        if (w_res > VMAX) begin
            w_sat = VMAX;
        end else if (w_res < VMIN) begin
            w_sat = VMIN;
        end else begin
            w_sat = w_res;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: r_x <= i_abscissa;
            OP_SHIFT: begin
                r_xm2 <= r_xa;   r_ym2 <= r_ya;
                r_xa  <= r_xb;   r_ya  <= r_yb;
                r_xb  <= w_rd_x; r_yb  <= w_rd_y;
            end
            OP_PICK: begin
                r_xc <= w_far_x;
                r_yc <= w_far_y;
            end
            OP_SUM_LIN:  r_sum <= {{(SW-XW){r_ya[XW-1]}}, r_ya};
            OP_SUM_ZERO: r_sum <= '0;
            OP_OPERANDS: begin
                r_my  <= mag(w_y);
                r_mn1 <= mag(w_n1);
                r_mn2 <= mag(w_n2);
                r_md1 <= mag(w_d1);
                r_md2 <= mag(w_d2);
                r_neg <= w_y[DW-1] ^ w_n1[DW-1] ^ w_n2[DW-1] ^ w_d1[DW-1] ^ w_d2[DW-1];
            end
            OP_MUL_N: r_p <= w_prod;
            OP_MUL_D: begin
                r_nn <= r_p;
                r_p  <= w_prod;
            end
            OP_MUL_LO: begin
                r_den <= r_p;
                r_p   <= w_prod;
            end
            OP_MUL_HI: begin
                r_num <= NUMW'(r_p);
                r_p   <= w_prod;
            end
            OP_NUM_ADD: r_num <= r_num + NUMW'({r_p, {DW{1'b0}}});
            OP_DIV_INIT: begin
                r_clamp <= w_num_hi >= r_den;
                r_rem   <= REMW'(r_num[NUMW-1:QW]);
                r_qsh   <= r_num[QW-1:0];
                r_q     <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? REMW'(w_trial - r_den) : REMW'(w_trial);
                r_qsh <= {r_qsh[QW-2:0], 1'b0};
                r_q   <= {r_q[QW-2:0], w_ge};
            end
            OP_ACC: r_sum <= r_sum + w_term;
            OP_RESULT: begin
                r_value  <= w_sat[XW-1:0];
                r_status <= i_cmd.status;
            end
            default: ;
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_RESULT);
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

`default_nettype wire

### sv/ti_ctrl.sv
// controller: configuration registers, segment scan and term sequencing
// depends on ti_pkg
`default_nettype none

module ti_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_kind,
    input  wire logic                           i_cfg_we,
    input  wire logic [ti_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire logic [ti_pkg::CFG_DW-1:0]      i_cfg_data,
    input  wire ti_pkg::t_st                    i_st,
    output      logic                           o_busy,
    output      ti_pkg::t_cmd                   o_cmd,
    output      logic [$clog2(TABLE_DEPTH)-1:0] o_raddr
);

    import ti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ((AW + 1) > 7) ? (AW + 1) : 7;

    t_state           r_state, n_state;
    logic [1:0]       r_method;
    logic [6:0]       r_count;
    logic [AW-1:0]    r_idx;
    t_term            r_term;
    logic [QCW-1:0]   r_cnt;

    // effective point count and segment position
    logic [CW-1:0] w_cnt_ext, w_n;
    logic          w_last, w_one, w_has_lo, w_has_hi;

    always_comb begin
        w_cnt_ext = CW'(r_count);
        if (w_cnt_ext == '0) begin
            w_n = CW'(1);
        end else if (w_cnt_ext > CW'(TABLE_DEPTH)) begin
            w_n = CW'(TABLE_DEPTH);
        end else begin
            w_n = w_cnt_ext;
        end
    end

    assign w_last   = CW'(r_idx) == (w_n - 1'b1);
    assign w_one    = w_n == CW'(1);
    assign w_has_lo = r_idx > AW'(1);
    assign w_has_hi = !w_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METHOD_LINEAR;
            r_count  <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_METHOD: r_method <= i_cfg_data[1:0];
                CFG_COUNT:  r_count  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start && i_kind) n_state = S_LOAD0;
            S_LOAD0: n_state = S_FIRST;
            S_FIRST: n_state = (i_st.le_first || w_one) ? S_IDLE : S_SCAN;
            S_SCAN: begin
                if (i_st.found) begin
                    if (r_method == METHOD_NEAREST) begin
                        n_state = S_NEAR;
                    end else if (r_method == METHOD_QUAD) begin
                        n_state = S_PICK;
                    end else begin
                        n_state = S_LINSET;
                    end
                end else if (w_last) begin
                    n_state = S_ABOVE;
                end
            end
            S_NEAR, S_ABOVE, S_FIN: n_state = S_IDLE;
            S_PICK: n_state = ((w_has_lo || w_has_hi) && !i_st.far_eq) ? S_QSET : S_LINSET;
            S_LINSET, S_QSET: n_state = S_OPS;
            S_OPS:     n_state = S_MULN;
            S_MULN:    n_state = S_MULD;
            S_MULD:    n_state = S_MULLO;
            S_MULLO:   n_state = S_MULHI;
            S_MULHI:   n_state = S_NUMADD;
            S_NUMADD:  n_state = S_DIVINIT;
            S_DIVINIT: n_state = S_DIV;
            S_DIV:     if (r_cnt == QCW'(QW - 1)) n_state = S_ACC;
            S_ACC: n_state = ((r_term == TERM_LIN) || (r_term == TERM_C)) ? S_FIN : S_OPS;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op      = OP_NONE;
        o_cmd.term    = r_term;
        o_cmd.res_sel = RES_B;
        o_cmd.status  = STAT_INSIDE;
        o_cmd.has_lo  = w_has_lo;
        o_cmd.has_hi  = w_has_hi;
        o_cmd.wr_en   = 1'b0;
        o_raddr       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind) begin
                        o_cmd.op = OP_CAPTURE;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_LOAD0: o_cmd.op = OP_SHIFT;
            S_FIRST: begin
                o_raddr = AW'(1);
                if (i_st.le_first) begin
                    o_cmd.op     = OP_RESULT;
                    o_cmd.status = i_st.lt_first ? STAT_BELOW : STAT_INSIDE;
                end else if (w_one) begin
                    o_cmd.op     = OP_RESULT;
                    o_cmd.status = STAT_ABOVE;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SHIFT;
                o_raddr  = r_idx + 1'b1;
            end
            S_NEAR: begin
                o_cmd.op      = OP_RESULT;
                o_cmd.res_sel = RES_NEAR;
            end
            S_ABOVE: begin
                o_cmd.op     = OP_RESULT;
                o_cmd.status = STAT_ABOVE;
            end
            S_PICK:    o_cmd.op = OP_PICK;
            S_LINSET:  o_cmd.op = OP_SUM_LIN;
            S_QSET:    o_cmd.op = OP_SUM_ZERO;
            S_OPS:     o_cmd.op = OP_OPERANDS;
            S_MULN:    o_cmd.op = OP_MUL_N;
            S_MULD:    o_cmd.op = OP_MUL_D;
            S_MULLO:   o_cmd.op = OP_MUL_LO;
            S_MULHI:   o_cmd.op = OP_MUL_HI;
            S_NUMADD:  o_cmd.op = OP_NUM_ADD;
            S_DIVINIT: o_cmd.op = OP_DIV_INIT;
            S_DIV:     o_cmd.op = OP_DIV_STEP;
            S_ACC:     o_cmd.op = OP_ACC;
            S_FIN: begin
                o_cmd.op      = OP_RESULT;
                o_cmd.res_sel = RES_SUM;
            end
            default: ;
        endcase
    end

    // state, segment index, term and divider step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_term  <= TERM_LIN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIRST) begin
                r_idx <= AW'(1);
            end else if (r_state == S_SCAN && !i_st.found && !w_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_LINSET) begin
                r_term <= TERM_LIN;
            end else if (r_state == S_QSET) begin
                r_term <= TERM_A;
            end else if (r_state == S_ACC) begin
                if (r_term == TERM_A) begin
                    r_term <= TERM_B;
                end else if (r_term == TERM_B) begin
                    r_term <= TERM_C;
                end
            end
            if (r_state == S_DIVINIT) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### sv/table_interpolator.sv
// table interpolator: a load is written in the cycle of start and never raises busy; a query
// scans the segments one at a time, then gives the result directly for nearest, at or below
// the first point or past the last point, or runs the 41-step restoring divider once per term:
// once for linear and for quadratic that falls back to linear, three times for quadratic
// the result strobe is high in the first cycle after busy falls; results cannot be held off
// synchronous active-low reset: mode linear, one point, table contents undefined
`default_nettype none
`include "table_interpolator_macros.svh"

module table_interpolator #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire logic                      i_kind,
    input  wire logic [5:0]                i_index,
    input  wire logic [ti_pkg::XW-1:0]     i_abscissa,
    input  wire logic [ti_pkg::XW-1:0]     i_ordinate,
    input  wire logic                      i_cfg_we,
    input  wire logic [ti_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [ti_pkg::CFG_DW-1:0] i_cfg_data,
    output      logic                      o_valid,
    output      logic [ti_pkg::XW-1:0]     o_value,
    output      logic [1:0]                o_status
);

    import ti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    t_cmd          w_cmd;
    t_st           w_st;
    logic [AW-1:0] w_raddr;

    // sequencing
    ti_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (i_kind),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_st       (w_st),
        .o_busy     (busy),
        .o_cmd      (w_cmd),
        .o_raddr    (w_raddr)
    );

    // table and arithmetic
    ti_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_raddr   (w_raddr),
        .i_index   (i_index),
        .i_abscissa(i_abscissa),
        .i_ordinate(i_ordinate),
        .o_st      (w_st),
        .o_valid   (o_valid),
        .o_value   (o_value),
        .o_status  (o_status)
    );

    // checks
    `TI_ASSERT_NOW(a_valid_after_busy, o_valid, $past(busy), "result without a query in flight")
    `TI_ASSERT_NEXT(a_load_no_result, start && !busy && !i_kind, !o_valid, "load produced a result")
    `TI_ASSERT_NEXT(a_query_busy, start && !busy && i_kind, busy, "query did not raise busy")
    `TI_ASSERT_NOW(a_status_code, o_valid, o_status != 2'd3, "invalid status code")

endmodule

`default_nettype wire

### verif/table_interpolator_tb.sv
// self-checking testbench for table_interpolator: loads tables, sets modes, checks queries
// depends on ti_pkg and the table_interpolator rtl; predicts every result internally
`timescale 1ns / 1ps

module table_interpolator_tb;

    import ti_pkg::*;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam int   DEPTH      = 64;
    localparam int   IDLE_LIMIT = 4000;

    // expected query results and the block's state as the predictor sees it
    class interp_scoreboard;
        longint      abs_tab[DEPTH];
        longint      ord_tab[DEPTH];
        logic [1:0]  mode;
        logic [6:0]  count;
        logic [31:0] exp_value[$];
        logic [1:0]  exp_status[$];
        int          mismatches;
        int          results_seen;
        int          queries;
        int          loads;

        function void reset_state();
            mode  = METHOD_LINEAR;
            count = 7'd1;
        endfunction

        function void note_config(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_METHOD)
                mode = data[1:0];
            else
                count = data;
        endfunction

        function int points_in_use();
            if (count == 0)
                return 1;
            return (count > DEPTH) ? DEPTH : int'(count);
        endfunction

        // trunc(y*n1*n2 / (d1*d2)) clamped to +-2^40
        function longint lagrange_term(longint y, longint n1, longint n2,
                                       longint d1, longint d2);
            logic        neg;
            logic [127:0] a, b, c, num, den, q;
            longint      m;
            neg = (y < 0) ^ (n1 < 0) ^ (n2 < 0) ^ (d1 < 0) ^ (d2 < 0);
            a   = (n1 < 0) ? -n1 : n1;
            b   = (n2 < 0) ? -n2 : n2;
            c   = (y < 0) ? -y : y;
            num = a * b * c;
            a   = (d1 < 0) ? -d1 : d1;
            b   = (d2 < 0) ? -d2 : d2;
            den = a * b;
            q   = num / den;
            m   = (q > (128'd1 << 40)) ? (64'sd1 <<< 40) : longint'(q[63:0]);
            return neg ? -m : m;
        endfunction

        function longint linear_value(longint x, int lo, int hi);
            return ord_tab[lo] + lagrange_term(ord_tab[hi] - ord_tab[lo], x - abs_tab[lo], 1,
                                               abs_tab[hi] - abs_tab[lo], 1);
        endfunction

        function longint interpolate(longint x, output logic [1:0] st);
            int     n, far;
            longint x0, x1, x2;
            n  = points_in_use();
            st = STAT_INSIDE;
            if (x <= abs_tab[0]) begin
                if (x < abs_tab[0])
                    st = STAT_BELOW;
                return ord_tab[0];
            end
            for (int i = 1; i < n; i++) begin
                x0 = abs_tab[i-1];
                x1 = abs_tab[i];
                if (x >= x0 && x < x1) begin
                    if (mode == METHOD_NEAREST)
                        return (x - x0 < x1 - x) ? ord_tab[i-1] : ord_tab[i];
                    if (mode != METHOD_QUAD)
                        return linear_value(x, i - 1, i);
                    far = -1;
                    if (i > 1 && i < n - 1)
                        far = (x - abs_tab[i-2] < abs_tab[i+1] - x) ? i - 2 : i + 1;
                    else if (i < n - 1)
                        far = i + 1;
                    else if (i > 1)
                        far = i - 2;
                    if (far < 0)
                        return linear_value(x, i - 1, i);
                    x2 = abs_tab[far];
                    if (x2 == x0 || x2 == x1)
                        return linear_value(x, i - 1, i);
                    return lagrange_term(ord_tab[i-1], x - x1, x - x2, x0 - x1, x0 - x2)
                         + lagrange_term(ord_tab[i], x - x0, x - x2, x1 - x0, x1 - x2)
                         + lagrange_term(ord_tab[far], x - x0, x - x1, x2 - x0, x2 - x1);
                end
            end
            st = STAT_ABOVE;
            return ord_tab[n-1];
        endfunction

        // an accepted request: loads update the table, queries queue a result
        function void note_request(logic kind, logic [5:0] idx, logic [31:0] x,
                                   logic [31:0] y);
            longint     v;
            logic [1:0] st;
            if (kind == KIND_LOAD) begin
                abs_tab[idx] = longint'($signed(x));
                ord_tab[idx] = longint'($signed(y));
                loads++;
                return;
            end
            v = interpolate(longint'($signed(x)), st);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            else if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            exp_value.push_back(v[31:0]);
            exp_status.push_back(st);
            queries++;
        endfunction

        function void check_result(logic [31:0] value, logic [1:0] st);
            logic [31:0] ev;
            logic [1:0]  es;
            results_seen++;
            if (exp_value.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d", value, st);
                return;
            end
            ev = exp_value.pop_front();
            es = exp_status.pop_front();
            if (value !== ev || st !== es) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected value=%h status=%0d, got value=%h status=%0d",
                             results_seen, ev, es, value, st);
            end
        endfunction

        function int pending();
            return exp_value.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_kind = KIND_LOAD;
    logic [5:0]          i_index = '0;
    logic [XW-1:0]       i_abscissa = '0;
    logic [XW-1:0]       i_ordinate = '0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;
    logic                o_valid;
    logic [XW-1:0]       o_value;
    logic [1:0]          o_status;

    interp_scoreboard sb;
    int               requests_sent;
    int               idle_cycles = 0;
    bit               no_gaps;

    table_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_index    (i_index),
        .i_abscissa (i_abscissa),
        .i_ordinate (i_ordinate),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_value    (o_value),
        .o_status   (o_status)
    );

    always #5 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_value, o_status);
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // one request; entered and left at a falling edge
    task automatic send_request(logic kind, logic [5:0] idx, logic [31:0] x, logic [31:0] y);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind     = kind;
        i_index    = idx;
        i_abscissa = x;
        i_ordinate = y;
        start      = 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_request(kind, idx, x, y);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_point(int idx, longint x, longint y);
        send_request(KIND_LOAD, idx[5:0], x[31:0], y[31:0]);
    endtask

    task automatic query_at(longint x);
        send_request(KIND_QUERY, 6'($urandom()), x[31:0], $urandom());
    endtask

    // register write once the block has drained
    task automatic write_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        start = 1'b0;
        while (sb.pending() > 0 || busy)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_data  = CFG_DW'($urandom());
        sb.note_config(idx, data);
    endtask

    function automatic longint random_ordinate();
        case ($urandom_range(0, 3))
            0:       return longint'($signed($urandom()));
            1:       return longint'($urandom_range(0, 1)) ? 64'sd2147483647 : -64'sd2147483648;
            default: return longint'($signed($urandom_range(0, 1 << 21))) - (1 << 20);
        endcase
    endfunction

    // fill slots 0..n-1 in one of several table shapes
    task automatic load_table(int n);
        int     shape;
        longint x;
        shape = $urandom_range(0, 4);
        case (shape)
            1:       x = -64'sd2147483648 + $urandom_range(0, 1000);
            default: x = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
        for (int i = 0; i < n; i++) begin
            load_point(i, x, random_ordinate());
            case (shape)
                1:       x += $urandom_range(1, (1 << 26) - 1);
                2:       x += (longint'($urandom_range(0, 10)) - 5) <<< 16;
                3:       x += $urandom_range(1, 4);
                default: x += $urandom_range(1, 1 << 17);
            endcase
        end
    endtask

    // a query position: inside a segment, on a point, outside, or anywhere
    function automatic longint pick_position();
        int     n, j;
        longint x0, x1;
        n = sb.points_in_use();
        j = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0:       return sb.abs_tab[j];
            1:       return sb.abs_tab[0] - $urandom_range(1, 1 << 16);
            2:       return sb.abs_tab[n-1] + $urandom_range(0, 1 << 16);
            3:       return longint'($signed($urandom()));
            4:       return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            default: begin
                if (j == 0)
                    j = (n > 1) ? 1 : 0;
                if (j == 0)
                    return sb.abs_tab[0];
                x0 = sb.abs_tab[j-1];
                x1 = sb.abs_tab[j];
                if (x1 <= x0)
                    return x0;
                return x0 + longint'($urandom()) % (x1 - x0);
            end
        endcase
    endfunction

    function automatic logic [6:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd64;
            3:       return 7'd2;
            4:       return 7'd3;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    initial begin
        logic [6:0] cnt;
        int         n, nq;
        sb = new();
        sb.reset_state();
        requests_sent = 0;
        no_gaps       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings with one point, extreme positions and values
        load_point(0, 0, 64'sd2147483647);
        query_at(-64'sd2147483648);
        query_at(0);
        query_at(64'sd2147483647);
        load_point(63, -64'sd2147483648, -64'sd2147483648);
        // three points in every mode, including method three
        write_register(CFG_COUNT, 7'd3);
        load_point(0, -64'sd65536, -64'sd2147483648);
        load_point(1, 0, 64'sd2147483647);
        load_point(2, 64'sd65536, -64'sd2147483648);
        for (int m = 0; m < 4; m++) begin
            write_register(CFG_METHOD, CFG_DW'(m));
            query_at(-32768);
            query_at(0);
            query_at(32768);
            query_at(65536);
        end
        // two points, then a duplicate third point, both in method three (linear)
        write_register(CFG_COUNT, 7'd2);
        query_at(100);
        write_register(CFG_COUNT, 7'd3);
        load_point(2, 0, 12345);
        query_at(-1000);

        // random phases
        while (requests_sent < 1050) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            write_register(CFG_METHOD, CFG_DW'($urandom_range(0, 3)));
            cnt = pick_count();
            write_register(CFG_COUNT, cnt);
            n = sb.points_in_use();
            load_table(n);
            nq = $urandom_range(8, 25);
            for (int k = 0; k < nq; k++) begin
                case ($urandom_range(0, 11))
                    0:       load_point(int'($urandom_range(0, 63)),
                                        longint'($signed($urandom())), random_ordinate());
                    default: query_at(pick_position());
                endcase
            end
        end

        start = 1'b0;
        while (sb.pending() > 0)
            @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("%0d loads and %0d queries sent, %0d results checked",
                 sb.loads, sb.queries, sb.results_seen);
        $display("modes nearest to quadratic, point counts from zero past the table depth");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
